>>> hw/rtl/csc_pkg.sv
// shared widths, types and the cordic angle table for the orbit/segment crossing pipeline
package csc_pkg;

  localparam int CSC_CORDIC_STEPS = 32;
  localparam int ATAN_LEN = 48;

  localparam int CW = 32;
  localparam int RADW = 31;
  localparam int AW = 32;
  localparam int MVW = AW + 1;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int FW = SW + 3;
  localparam int RRW = 2 * RADW;
  localparam int SPL = 33;
  localparam int AMW = 2 * SPL;
  localparam int PRW = 4 * SPL;
  localparam int QW = 128;
  localparam int RW = QW / 2;
  localparam int HW = RW / 2;
  localparam int PPW = DW + SPL + 1;
  localparam int VW = 100;
  localparam int MW = VW - 1;
  localparam int NORM_STAGES = 7;
  localparam int FRW = 30;
  localparam int CXW = 34;
  localparam int QUAD_STAGES = 7;
  localparam int DIR_STAGES = 3;
  localparam int ANG_FIX_LAT = NORM_STAGES + 2;

  localparam logic [AW-1:0] HALF_TURN = {1'b1, {(AW-1){1'b0}}};
  localparam logic [MVW-1:0] FULL_TURN = {1'b1, {AW{1'b0}}};

  localparam logic [AW-1:0] ATAN_TURN [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  typedef struct packed {
    logic            live;
    logic            vlow;
    logic            vhigh;
    logic [AW-1:0]   cur;
  } csc_tag_t;

  typedef struct packed {
    csc_tag_t               tag;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic signed [SW-1:0]   xc;
  } csc_side_t;

endpackage

>>> hw/rtl/csc_quad.sv
// geometry, root validity tests and discriminant pipeline
module csc_quad
  import csc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   ce,
  input  logic                   valid_i,
  input  logic signed [CW-1:0]   center_x,
  input  logic signed [CW-1:0]   center_y,
  input  logic [RADW-1:0]        radius,
  input  logic [AW-1:0]          current_angle,
  input  logic signed [CW-1:0]   seg_begin_x,
  input  logic signed [CW-1:0]   seg_begin_y,
  input  logic signed [CW-1:0]   seg_end_x,
  input  logic signed [CW-1:0]   seg_end_y,
  output logic                   valid_o,
  output logic [QW-1:0]          disc_o,
  output csc_side_t              side_o
);

  logic [QUAD_STAGES-1:0] vld_r;

  logic signed [DW-1:0] dx1_r, dy1_r, px1_r, py1_r;
  logic [RADW-1:0]      rad1_r;
  logic [AW-1:0]        cur1_r;

  logic signed [PW-1:0] dxdx2_r, dydy2_r, dxpx2_r, dypy2_r, pxpx2_r, pypy2_r;
  logic signed [PW-1:0] dxpy2_r, dypx2_r;
  logic [RRW-1:0]       rr2_r;
  logic signed [DW-1:0] dx2_r, dy2_r;
  logic [AW-1:0]        cur2_r;

  logic signed [SW-1:0] a3_r, h3_r, c3_r, x3_r;
  logic [RRW-1:0]       rr3_r;
  logic signed [DW-1:0] dx3_r, dy3_r;
  logic [AW-1:0]        cur3_r;

  logic signed [FW-1:0] ha_nxt, f1_nxt;
  logic                 hneg, cpos, cneg, hapos, f1pos, f1neg;
  logic [AMW-1:0]       ax_nxt;
  logic [SW-1:0]        xabs;

  logic [AMW-1:0]       a4_r, ax4_r;
  logic [RRW-1:0]       rr4_r;
  logic                 azero4_r, vlow4_r, vhigh4_r;
  logic signed [DW-1:0] dx4_r, dy4_r;
  logic signed [SW-1:0] x4_r;
  logic [AW-1:0]        cur4_r;

  logic [AMW-1:0]       arll5_r, arlh5_r, arhl5_r, arhh5_r;
  logic [AMW-1:0]       xll5_r, xlh5_r, xhl5_r, xhh5_r;
  logic                 azero5_r, vlow5_r, vhigh5_r;
  logic signed [DW-1:0] dx5_r, dy5_r;
  logic signed [SW-1:0] x5_r;
  logic [AW-1:0]        cur5_r;

  logic [PRW-1:0]       ar6_r, x26_r;
  logic                 azero6_r, vlow6_r, vhigh6_r;
  logic signed [DW-1:0] dx6_r, dy6_r;
  logic signed [SW-1:0] x6_r;
  logic [AW-1:0]        cur6_r;

  logic                 dneg;
  logic [QW-1:0]        disc_r;
  csc_side_t            side_r;
  csc_side_t            side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[QUAD_STAGES-2:0], valid_i};
    end
  end

  // stage 1: differences
  always_ff @(posedge clk) begin
    if (ce) begin
      dx1_r  <= DW'(seg_end_x) - DW'(seg_begin_x);
      dy1_r  <= DW'(seg_end_y) - DW'(seg_begin_y);
      px1_r  <= DW'(seg_begin_x) - DW'(center_x);
      py1_r  <= DW'(seg_begin_y) - DW'(center_y);
      rad1_r <= radius;
      cur1_r <= current_angle;
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (ce) begin
      dxdx2_r <= dx1_r * dx1_r;
      dydy2_r <= dy1_r * dy1_r;
      dxpx2_r <= dx1_r * px1_r;
      dypy2_r <= dy1_r * py1_r;
      pxpx2_r <= px1_r * px1_r;
      pypy2_r <= py1_r * py1_r;
      dxpy2_r <= dx1_r * py1_r;
      dypx2_r <= dy1_r * px1_r;
      rr2_r   <= rad1_r * rad1_r;
      dx2_r   <= dx1_r;
      dy2_r   <= dy1_r;
      cur2_r  <= cur1_r;
    end
  end

  // stage 3: quadratic coefficients and cross product
  always_ff @(posedge clk) begin
    if (ce) begin
      a3_r   <= SW'(dxdx2_r) + SW'(dydy2_r);
      h3_r   <= SW'(dxpx2_r) + SW'(dypy2_r);
      c3_r   <= SW'(pxpx2_r) + SW'(pypy2_r) - $signed({{(SW-RRW){1'b0}}, rr2_r});
      x3_r   <= SW'(dxpy2_r) - SW'(dypx2_r);
      rr3_r  <= rr2_r;
      dx3_r  <= dx2_r;
      dy3_r  <= dy2_r;
      cur3_r <= cur2_r;
    end
  end

  // stage 4: root tests
  always_comb begin
    ha_nxt = FW'(h3_r) + FW'(a3_r);
    f1_nxt = FW'(a3_r) + FW'(h3_r) + FW'(h3_r) + FW'(c3_r);
    hneg   = h3_r[SW-1];
    cneg   = c3_r[SW-1];
    cpos   = !cneg && (|c3_r);
    hapos  = !ha_nxt[FW-1] && (|ha_nxt);
    f1neg  = f1_nxt[FW-1];
    f1pos  = !f1neg && (|f1_nxt);
    xabs   = x3_r[SW-1] ? SW'(-x3_r) : SW'(x3_r);
    ax_nxt = xabs[AMW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a4_r     <= a3_r[AMW-1:0];
      ax4_r    <= ax_nxt;
      rr4_r    <= rr3_r;
      azero4_r <= (a3_r == '0);
      vlow4_r  <= hneg && cpos && (hapos || f1neg);
      vhigh4_r <= (hneg || cneg) && hapos && f1pos;
      dx4_r    <= dx3_r;
      dy4_r    <= dy3_r;
      x4_r     <= x3_r;
      cur4_r   <= cur3_r;
    end
  end

  // stage 5: partial products of a*r^2 and x^2
  always_ff @(posedge clk) begin
    if (ce) begin
      arll5_r  <= a4_r[SPL-1:0] * rr4_r[SPL-1:0];
      arlh5_r  <= AMW'(a4_r[SPL-1:0] * rr4_r[RRW-1:SPL]);
      arhl5_r  <= a4_r[AMW-1:SPL] * rr4_r[SPL-1:0];
      arhh5_r  <= AMW'(a4_r[AMW-1:SPL] * rr4_r[RRW-1:SPL]);
      xll5_r   <= ax4_r[SPL-1:0] * ax4_r[SPL-1:0];
      xlh5_r   <= ax4_r[SPL-1:0] * ax4_r[AMW-1:SPL];
      xhl5_r   <= ax4_r[AMW-1:SPL] * ax4_r[SPL-1:0];
      xhh5_r   <= ax4_r[AMW-1:SPL] * ax4_r[AMW-1:SPL];
      azero5_r <= azero4_r;
      vlow5_r  <= vlow4_r;
      vhigh5_r <= vhigh4_r;
      dx5_r    <= dx4_r;
      dy5_r    <= dy4_r;
      x5_r     <= x4_r;
      cur5_r   <= cur4_r;
    end
  end

  // stage 6: partial product sums
  always_ff @(posedge clk) begin
    if (ce) begin
      ar6_r <= PRW'(arll5_r) + (PRW'(arlh5_r) << SPL) + (PRW'(arhl5_r) << SPL)
             + (PRW'(arhh5_r) << AMW);
      x26_r <= PRW'(xll5_r) + (PRW'(xlh5_r) << SPL) + (PRW'(xhl5_r) << SPL)
             + (PRW'(xhh5_r) << AMW);
      azero6_r <= azero5_r;
      vlow6_r  <= vlow5_r;
      vhigh6_r <= vhigh5_r;
      dx6_r    <= dx5_r;
      dy6_r    <= dy5_r;
      x6_r     <= x5_r;
      cur6_r   <= cur5_r;
    end
  end

  // stage 7: discriminant a*r^2 - x^2
  always_comb begin
    dneg              = x26_r > ar6_r;
    side_nxt.tag.live = !azero6_r && !dneg && (vlow6_r || vhigh6_r);
    side_nxt.tag.vlow = vlow6_r;
    side_nxt.tag.vhigh = vhigh6_r;
    side_nxt.tag.cur  = cur6_r;
    side_nxt.dx       = dx6_r;
    side_nxt.dy       = dy6_r;
    side_nxt.xc       = x6_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      disc_r <= dneg ? '0 : QW'(ar6_r - x26_r);
      side_r <= side_nxt;
    end
  end

  assign valid_o = vld_r[QUAD_STAGES-1];
  assign disc_o  = disc_r;
  assign side_o  = side_r;

endmodule

>>> hw/rtl/csc_sqrt.sv
// pipelined integer square root, one result bit per stage
module csc_sqrt
  import csc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ce,
  input  logic              valid_i,
  input  logic [QW-1:0]     disc_i,
  input  csc_side_t         side_i,
  output logic              valid_o,
  output logic [RW-1:0]     root_o,
  output csc_side_t         side_o
);

  localparam int TW = QW + 1;

  logic [QW-1:0] rem_r [RW];
  logic [RW-1:0] q_r [RW];
  csc_side_t     side_r [RW];
  logic [RW-1:0] vld_r;

  for (genvar j = 0; j < RW; j++) begin : g_step
    localparam int B = RW - 1 - j;
    logic [QW-1:0] rem_in;
    logic [RW-1:0] q_in;
    csc_side_t     side_in;
    logic          vld_in;
    logic [TW-1:0] trial;
    logic          take;
    logic [QW-1:0] rem_nxt;
    logic [RW-1:0] q_nxt;

    if (j == 0) begin : g_first
      assign rem_in  = disc_i;
      assign q_in    = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign q_in    = q_r[j-1];
      assign side_in = side_r[j-1];
      assign vld_in  = vld_r[j-1];
    end

    // (q + 2^b)^2 - q^2
    assign trial   = (TW'(q_in) << (B + 1)) | (TW'(1) << (2 * B));
    assign take    = TW'(rem_in) >= trial;
    assign rem_nxt = take ? (rem_in - trial[QW-1:0]) : rem_in;
    assign q_nxt   = q_in | (RW'(take) << B);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (ce) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[j]  <= rem_nxt;
        q_r[j]    <= q_nxt;
        side_r[j] <= side_in;
      end
    end
  end

  assign valid_o = vld_r[RW-1];
  assign root_o  = q_r[RW-1];
  assign side_o  = side_r[RW-1];

endmodule

>>> hw/rtl/csc_dir.sv
// crossing direction vectors for the lower and upper roots
module csc_dir
  import csc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ce,
  input  logic                  valid_i,
  input  logic [RW-1:0]         root_i,
  input  csc_side_t             side_i,
  output logic                  valid_o,
  output logic signed [VW-1:0]  lx_o,
  output logic signed [VW-1:0]  ly_o,
  output logic signed [VW-1:0]  ux_o,
  output logic signed [VW-1:0]  uy_o,
  output csc_tag_t              tag_o
);

  logic [DIR_STAGES-1:0] vld_r;

  logic signed [SPL:0]   xl, xh;
  logic signed [SPL-1:0] wl, wh;

  logic signed [PPW-1:0] dyxl1_r, dyxh1_r, dxxl1_r, dxxh1_r;
  logic signed [PPW-1:0] dxwl1_r, dxwh1_r, dywl1_r, dywh1_r;
  csc_tag_t              tag1_r;

  logic signed [VW-1:0]  dyx2_r, dxx2_r, wdx2_r, wdy2_r;
  csc_tag_t              tag2_r;

  logic signed [VW-1:0]  lx3_r, ly3_r, ux3_r, uy3_r;
  csc_tag_t              tag3_r;

  assign xl = $signed({1'b0, side_i.xc[SPL-1:0]});
  assign xh = side_i.xc[SW-1:SPL];
  assign wl = $signed({1'b0, root_i[HW-1:0]});
  assign wh = $signed({1'b0, root_i[RW-1:HW]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[DIR_STAGES-2:0], valid_i};
    end
  end

  // partial products
  always_ff @(posedge clk) begin
    if (ce) begin
      dyxl1_r <= side_i.dy * xl;
      dyxh1_r <= side_i.dy * xh;
      dxxl1_r <= side_i.dx * xl;
      dxxh1_r <= side_i.dx * xh;
      dxwl1_r <= side_i.dx * wl;
      dxwh1_r <= side_i.dx * wh;
      dywl1_r <= side_i.dy * wl;
      dywh1_r <= side_i.dy * wh;
      tag1_r  <= side_i.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dyx2_r <= (VW'(dyxh1_r) <<< SPL) + VW'(dyxl1_r);
      dxx2_r <= (VW'(dxxh1_r) <<< SPL) + VW'(dxxl1_r);
      wdx2_r <= (VW'(dxwh1_r) <<< HW) + VW'(dxwl1_r);
      wdy2_r <= (VW'(dywh1_r) <<< HW) + VW'(dywl1_r);
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      lx3_r  <= -dyx2_r - wdx2_r;
      ly3_r  <= dxx2_r - wdy2_r;
      ux3_r  <= -dyx2_r + wdx2_r;
      uy3_r  <= dxx2_r + wdy2_r;
      tag3_r <= tag2_r;
    end
  end

  assign valid_o = vld_r[DIR_STAGES-1];
  assign lx_o    = lx3_r;
  assign ly_o    = ly3_r;
  assign ux_o    = ux3_r;
  assign uy_o    = uy3_r;
  assign tag_o   = tag3_r;

endmodule

>>> hw/rtl/csc_angle.sv
// vector angle: magnitude, staged normalization, pipelined cordic vectoring
module csc_angle
  import csc_pkg::*;
#(
  parameter int STEPS = CSC_CORDIC_STEPS
)
(
  input  logic                  clk,
  input  logic                  ce,
  input  logic signed [VW-1:0]  vx_i,
  input  logic signed [VW-1:0]  vy_i,
  output logic [AW-1:0]         ang_o
);

  logic [MW-1:0]        mx_r [NORM_STAGES+1];
  logic [MW-1:0]        my_r [NORM_STAGES+1];
  logic [NORM_STAGES:0] nx_r, ny_r;
  logic [VW-1:0]        ax_nxt, ay_nxt;

  logic signed [CXW-1:0] cx_r [STEPS+1];
  logic signed [CXW-1:0] cy_r [STEPS+1];
  logic [AW-1:0]         ca_r [STEPS+1];
  logic [STEPS:0]        zero_r;

  logic [FRW-1:0]        fx, fy;
  logic                  flip, yneg;
  logic signed [CXW-1:0] fy_s;

  assign ax_nxt = vx_i[VW-1] ? VW'(-vx_i) : VW'(vx_i);
  assign ay_nxt = vy_i[VW-1] ? VW'(-vy_i) : VW'(vy_i);

  always_ff @(posedge clk) begin
    if (ce) begin
      mx_r[0] <= ax_nxt[MW-1:0];
      my_r[0] <= ay_nxt[MW-1:0];
      nx_r[0] <= vx_i[VW-1];
      ny_r[0] <= vy_i[VW-1];
    end
  end

  // left-justify the larger magnitude
  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    localparam int SH = 1 << (NORM_STAGES - 1 - k);
    logic [MW-1:0] mor;
    logic          sel;
    assign mor = mx_r[k] | my_r[k];
    assign sel = (mor[MW-1 -: SH] == '0);
    always_ff @(posedge clk) begin
      if (ce) begin
        mx_r[k+1] <= sel ? (mx_r[k] << SH) : mx_r[k];
        my_r[k+1] <= sel ? (my_r[k] << SH) : my_r[k];
        nx_r[k+1] <= nx_r[k];
        ny_r[k+1] <= ny_r[k];
      end
    end
  end

  // signs back, fold into the right half plane
  always_comb begin
    fx   = mx_r[NORM_STAGES][MW-1 -: FRW];
    fy   = my_r[NORM_STAGES][MW-1 -: FRW];
    flip = nx_r[NORM_STAGES] && (|fx);
    yneg = ny_r[NORM_STAGES] ^ flip;
    fy_s = $signed(CXW'(fy));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cx_r[0]   <= $signed(CXW'(fx));
      cy_r[0]   <= yneg ? -fy_s : fy_s;
      ca_r[0]   <= flip ? HALF_TURN : '0;
      zero_r[0] <= !(mx_r[NORM_STAGES][MW-1] || my_r[NORM_STAGES][MW-1]);
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    logic signed [CXW-1:0] xs, ys;
    logic                  ypos;
    assign xs   = cx_r[i] >>> i;
    assign ys   = cy_r[i] >>> i;
    assign ypos = !cy_r[i][CXW-1] && (|cy_r[i]);
    always_ff @(posedge clk) begin
      if (ce) begin
        cx_r[i+1]   <= ypos ? (cx_r[i] + ys) : (cx_r[i] - ys);
        cy_r[i+1]   <= ypos ? (cy_r[i] - xs) : (cy_r[i] + xs);
        ca_r[i+1]   <= ypos ? (ca_r[i] + ATAN_TURN[i]) : (ca_r[i] - ATAN_TURN[i]);
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  assign ang_o = zero_r[STEPS] ? '0 : ca_r[STEPS];

endmodule

>>> hw/rtl/circle_segment_collision_angle.sv
// top level: forward rotation on a circular orbit to its first segment crossing
// Fully pipelined: one word is accepted per clock while no stall is held, and each word
// gives one result word. The path runs through 7 stages of geometry and discriminant
// math, 64 stages of the bit-per-stage square root of the 128-bit discriminant, 3 stages
// of crossing-vector products, 9 stages of magnitude and normalization plus one stage
// per cordic step, and the output register.
// A stall on the result side freezes the whole pipeline and is passed to the input.
module circle_segment_collision_angle
  import csc_pkg::*;
#(
  parameter int CORDIC_STEPS = CSC_CORDIC_STEPS
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [CW-1:0]  in_center_x,
  input  logic signed [CW-1:0]  in_center_y,
  input  logic [RADW-1:0]       in_radius,
  input  logic [AW-1:0]         in_current_angle,
  input  logic signed [CW-1:0]  in_seg_begin_x,
  input  logic signed [CW-1:0]  in_seg_begin_y,
  input  logic signed [CW-1:0]  in_seg_end_x,
  input  logic signed [CW-1:0]  in_seg_end_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [MVW-1:0]        out_move_angle
);

  localparam int ANG_LAT = ANG_FIX_LAT + CORDIC_STEPS;

  logic                 ce;
  logic                 q_valid, s_valid, d_valid;
  logic [QW-1:0]        disc;
  csc_side_t            q_side, s_side;
  logic [RW-1:0]        root;
  logic signed [VW-1:0] lx, ly, ux, uy;
  csc_tag_t             d_tag;
  logic [AW-1:0]        ang_l, ang_u;

  csc_tag_t             tag_r [ANG_LAT];
  logic [ANG_LAT-1:0]   vld_r;

  logic [AW-1:0]        diff_l, diff_u;
  logic [MVW-1:0]       mv_l, mv_u, best;
  csc_tag_t             tag_end;

  logic                 out_valid_r, out_hit_r;
  logic [MVW-1:0]       out_move_r;

  assign ce       = !(out_valid_r && out_stall);
  assign in_stall = !ce;

  csc_quad u_quad (
    .clk           (clk),
    .rst_n         (rst_n),
    .ce            (ce),
    .valid_i       (in_valid),
    .center_x      (in_center_x),
    .center_y      (in_center_y),
    .radius        (in_radius),
    .current_angle (in_current_angle),
    .seg_begin_x   (in_seg_begin_x),
    .seg_begin_y   (in_seg_begin_y),
    .seg_end_x     (in_seg_end_x),
    .seg_end_y     (in_seg_end_y),
    .valid_o       (q_valid),
    .disc_o        (disc),
    .side_o        (q_side)
  );

  csc_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .valid_i (q_valid),
    .disc_i  (disc),
    .side_i  (q_side),
    .valid_o (s_valid),
    .root_o  (root),
    .side_o  (s_side)
  );

  csc_dir u_dir (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .valid_i (s_valid),
    .root_i  (root),
    .side_i  (s_side),
    .valid_o (d_valid),
    .lx_o    (lx),
    .ly_o    (ly),
    .ux_o    (ux),
    .uy_o    (uy),
    .tag_o   (d_tag)
  );

  csc_angle #(.STEPS(CORDIC_STEPS)) u_angle_low (
    .clk   (clk),
    .ce    (ce),
    .vx_i  (lx),
    .vy_i  (ly),
    .ang_o (ang_l)
  );

  csc_angle #(.STEPS(CORDIC_STEPS)) u_angle_high (
    .clk   (clk),
    .ce    (ce),
    .vx_i  (ux),
    .vy_i  (uy),
    .ang_o (ang_u)
  );

  // tags ride alongside the angle lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[ANG_LAT-2:0], d_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      tag_r[0] <= d_tag;
      for (int n = 1; n < ANG_LAT; n++) begin
        tag_r[n] <= tag_r[n-1];
      end
    end
  end

  // pick the nearer forward rotation, zero rotation counts as a full turn
  always_comb begin
    tag_end = tag_r[ANG_LAT-1];
    diff_l  = ang_l - tag_end.cur;
    diff_u  = ang_u - tag_end.cur;
    mv_l    = (diff_l == '0) ? FULL_TURN : {1'b0, diff_l};
    mv_u    = (diff_u == '0) ? FULL_TURN : {1'b0, diff_u};
    if (tag_end.vlow && tag_end.vhigh) begin
      best = (mv_l < mv_u) ? mv_l : mv_u;
    end else if (tag_end.vlow) begin
      best = mv_l;
    end else begin
      best = mv_u;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= vld_r[ANG_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_hit_r  <= tag_end.live;
      out_move_r <= tag_end.live ? best : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_move_angle = out_move_r;

endmodule

>>> verif/tb_circle_segment_collision_angle.sv
// testbench for circle_segment_collision_angle: bit-exact crossing predictor and scoreboard
module tb_circle_segment_collision_angle;
  import csc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] cx, cy;
    logic [RADW-1:0]      rad;
    logic [AW-1:0]        cur;
    logic signed [CW-1:0] bx, by, ex, ey;
  } orbit_seg_t;

  typedef struct {
    logic           hit;
    logic [MVW-1:0] move;
  } crossing_t;

  function automatic logic [AW-1:0] dir_angle(wide_t vx, wide_t vy);
    wide_t mx, my;
    int nb;
    longint x, y, xs, ys;
    logic [AW-1:0] ang;
    mx = vx[255] ? -vx : vx;
    my = vy[255] ? -vy : vy;
    nb = 0;
    for (int i = 254; i >= 0; i--) begin
      if (nb == 0 && (mx[i] || my[i])) nb = i + 1;
    end
    if (nb == 0) return '0;
    if (nb > FRW) begin
      mx = mx >> (nb - FRW);
      my = my >> (nb - FRW);
    end else begin
      mx = mx << (FRW - nb);
      my = my << (FRW - nb);
    end
    x = longint'(mx[31:0]);
    y = longint'(my[31:0]);
    if (vx[255]) x = -x;
    if (vy[255]) y = -y;
    ang = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = HALF_TURN;
    end
    for (int i = 0; i < CSC_CORDIC_STEPS; i++) begin
      ys = y >>> i;
      xs = x >>> i;
      if (y > 0) begin
        x += ys; y -= xs; ang += ATAN_TURN[i];
      end else begin
        x -= ys; y += xs; ang -= ATAN_TURN[i];
      end
    end
    return ang;
  endfunction

  function automatic crossing_t predict_crossing(orbit_seg_t it);
    wide_t dx, dy, px, py, rr, a, h, c, f1, ha, xp, d, root, cand, bxv, byv, wdx, wdy;
    logic vlow, vhigh;
    logic [AW-1:0] ang, diff;
    logic [MVW-1:0] best, mv;
    crossing_t res;
    dx = wide_t'(it.ex) - wide_t'(it.bx);
    dy = wide_t'(it.ey) - wide_t'(it.by);
    px = wide_t'(it.bx) - wide_t'(it.cx);
    py = wide_t'(it.by) - wide_t'(it.cy);
    rr = wide_t'({1'b0, it.rad});
    a = dx * dx + dy * dy;
    h = dx * px + dy * py;
    c = px * px + py * py - rr * rr;
    f1 = a + h + h + c;
    ha = h + a;
    xp = dx * py - dy * px;
    d = h * h - a * c;
    res.hit = 1'b0;
    res.move = '0;
    if (a == 0 || d < 0) return res;
    vlow = h < 0 && c > 0 && (ha > 0 || f1 < 0);
    vhigh = (h < 0 || c < 0) && ha > 0 && f1 > 0;
    if (!vlow && !vhigh) return res;
    root = 0;
    for (int i = 66; i >= 0; i--) begin
      cand = root | (wide_t'(1) << i);
      if (cand * cand <= d) root = cand;
    end
    bxv = -(dy * xp);
    byv = dx * xp;
    wdx = root * dx;
    wdy = root * dy;
    best = FULL_TURN;
    for (int k = 0; k < 2; k++) begin
      if ((k == 0 && vlow) || (k == 1 && vhigh)) begin
        ang = (k == 0) ? dir_angle(bxv - wdx, byv - wdy) : dir_angle(bxv + wdx, byv + wdy);
        diff = ang - it.cur;
        mv = (diff == 0) ? FULL_TURN : {1'b0, diff};
        if (mv < best) best = mv;
      end
    end
    res.hit = 1'b1;
    res.move = best;
    return res;
  endfunction

  class crossing_board;
    crossing_t pending[$];
    int fails, words_in, hits, misses;

    function void note_word(orbit_seg_t it);
      pending.push_back(predict_crossing(it));
      words_in++;
    endfunction

    function void check_word(logic hit, logic [MVW-1:0] move);
      crossing_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing pending: hit=%0b move_angle=%0d", hit, move);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) begin
        $error("hit: expected %0b, actual %0b", e.hit, hit);
        fails++;
      end
      if (move !== e.move) begin
        $error("move_angle: expected %0d, actual %0d", e.move, move);
        fails++;
      end
      if (e.hit) hits++; else misses++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [CW-1:0] in_center_x = 0, in_center_y = 0;
  logic [RADW-1:0] in_radius = 0;
  logic [AW-1:0] in_current_angle = 0;
  logic signed [CW-1:0] in_seg_begin_x = 0, in_seg_begin_y = 0;
  logic signed [CW-1:0] in_seg_end_x = 0, in_seg_end_y = 0;
  logic out_valid;
  logic out_stall = 0;
  logic out_hit;
  logic [MVW-1:0] out_move_angle;

  crossing_board board = new();
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0;
  int quiet = 0;

  circle_segment_collision_angle DUT (.*);

  always #4 clk = ~clk;

  always @(negedge clk) out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_word(out_hit, out_move_angle);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(orbit_seg_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_center_x <= it.cx;
    in_center_y <= it.cy;
    in_radius <= it.rad;
    in_current_angle <= it.cur;
    in_seg_begin_x <= it.bx;
    in_seg_begin_y <= it.by;
    in_seg_end_x <= it.ex;
    in_seg_end_y <= it.ey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(it);
    @(negedge clk);
  endtask

  function automatic orbit_seg_t make_word(int cx, int cy, int rad, int cur,
                                           int bx, int by, int ex, int ey);
    orbit_seg_t it;
    it.cx = cx; it.cy = cy; it.rad = RADW'(rad); it.cur = cur;
    it.bx = bx; it.by = by; it.ex = ex; it.ey = ey;
    return it;
  endfunction

  function automatic orbit_seg_t random_word();
    orbit_seg_t it;
    int sh;
    longint r, cx, cy;
    it.cur = $urandom;
    if ($urandom_range(99) < 25) begin
      it.cx = $urandom; it.cy = $urandom; it.rad = RADW'($urandom);
      it.bx = $urandom; it.by = $urandom; it.ex = $urandom; it.ey = $urandom;
      return it;
    end
    sh = $urandom_range(27, 4);
    r = $urandom_range(1 << sh, 1);
    cx = longint'($signed($urandom)) >>> (31 - sh);
    cy = longint'($signed($urandom)) >>> (31 - sh);
    it.cx = CW'(cx); it.cy = CW'(cy); it.rad = RADW'(r);
    if ($urandom_range(1)) begin
      it.bx = CW'(cx + longint'($urandom_range(r, 0)) - r / 2);
      it.by = CW'(cy + longint'($urandom_range(r, 0)) - r / 2);
    end else begin
      it.bx = CW'(cx + longint'($urandom_range(4 * r, 0)) - 2 * r);
      it.by = CW'(cy + longint'($urandom_range(4 * r, 0)) - 2 * r);
    end
    it.ex = CW'(cx + longint'($urandom_range(8 * r, 0)) - 4 * r);
    it.ey = CW'(cy + longint'($urandom_range(8 * r, 0)) - 4 * r);
    return it;
  endfunction

  initial begin
    orbit_seg_t it;
    crossing_t pre;
    int lim;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words
    send_word(make_word(0, 0, 100, 0, 50, 50, 50, 50));
    send_word(make_word(0, 0, 100, 0, 500, 500, 900, 700));
    send_word(make_word(0, 0, 100, 0, -10, 5, 10, 5));
    send_word(make_word(0, 0, 1000, 123, -2000, 1000, 2000, 1000));
    send_word(make_word(0, 0, 0, 77, -5, 0, 5, 0));
    send_word(make_word(0, 0, 65536, 0, 0, 0, 200000, 0));
    send_word(make_word(0, 0, 65536, 0, -200000, 3000, 200000, -3000));
    send_word(make_word(100, -100, 65536, 32'h8000_0000, 100, 300000, 100, -300000));
    send_word(make_word(32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff, 32'hffff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
    send_word(make_word(32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 0,
                        32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    send_word(make_word(0, 0, 31'h7fff_ffff, 32'hffff_ffff,
                        32'h8000_0000, 0, 32'h7fff_ffff, 0));
    send_word(make_word(0, 0, 31'h7fff_ffff, 5,
                        32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    send_word(make_word(-1, -1, 0, 0, -1, -1, -1, -1));
    for (int i = 0; i < 6; i++) begin
      it = random_word();
      it.cur = 0;
      pre = predict_crossing(it);
      if (pre.hit) it.cur = pre.move[AW-1:0];
      send_word(it);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 85 : 0;
      recv_stall_pct = (ph == 0) ? 85 : (ph == 1) ? 15 : 0;
      for (int n = 0; n < 630; n++) begin
        if (ph == 2 && n == 100) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (400) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        send_word(random_word());
      end
    end
    in_valid <= 1'b0;

    lim = 0;
    while (board.pending.size() != 0 && lim < 100000) begin
      @(posedge clk);
      lim++;
    end
    repeat (150) @(posedge clk);
    if (board.pending.size() != 0) begin
      $error("%0d results never arrived", board.pending.size());
      board.fails++;
    end
    $display("covered %0d words (%0d crossings, %0d misses) under three idle/stall mixes",
             board.words_in, board.hits, board.misses);
    $display("including a long result-side hold that backed up the input");
    if (board.fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/csc_pkg.sv
hw/rtl/csc_quad.sv
hw/rtl/csc_sqrt.sv
hw/rtl/csc_dir.sv
hw/rtl/csc_angle.sv
hw/rtl/circle_segment_collision_angle.sv
verif/tb_circle_segment_collision_angle.sv
